### rtl/dlas_pkg.sv
package dlas_pkg;

    // Field widths of the stream words.
    localparam int ProgW   = 11;
    localparam int TimeW   = 32;
    localparam int SlotW   = 4;
    localparam int DurW    = 16;
    localparam int InDataW = 64;
    localparam int OutDataW = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    // Pre-wake ramp: numerator is min(elapsed, ramp_ms) * 25, quotient at most 25 for a nonzero ramp_ms.
    localparam int NumW  = 37;
    localparam int QuotW = 5;

    localparam logic [7:0]  PrewakeTop = 8'd25;
    localparam logic [7:0]  RedFull    = 8'd255;
    localparam logic [7:0]  GreenFull  = 8'd180;
    localparam logic [6:0]  BlueFull   = 7'd120;
    localparam logic [10:0] ProgFull   = 11'd1024;
    localparam logic [10:0] ProgHalf   = 11'd512;
    localparam logic [19:0] GreenKnee  = 20'd122880;
    localparam logic [19:0] BlueKnee   = 20'd184320;
    // 23 * 6554: x * 230 / 50 as x * 23 times a 2^-15 scaled reciprocal of 5.
    localparam logic [17:0] DawnRedMul = 18'd150742;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_STOP   = 2'd1,
        OP_LOAD   = 2'd2
    } opcode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RAMP_MS       = 3'd0,
        REG_FLASH_THRESH  = 3'd1,
        REG_FLASH_PERIOD  = 3'd2,
        REG_BUZZER_THRESH = 3'd3,
        REG_NOTE_COUNT    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] ramp_ms;
        logic [10:0] flash_threshold;
        logic [15:0] flash_period_ms;
        logic [10:0] buzzer_threshold;
        logic [4:0]  note_count;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic div_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic    div_done;
        logic    out_free;
    } dp_status_t;

endpackage

### rtl/dlas_cfg.sv
module dlas_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dlas_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [dlas_pkg::CfgDataW-1:0] cfg_data,
    output dlas_pkg::cfg_t                cfg
);
    import dlas_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_ms          <= 32'd600000;
            cfg_reg.flash_threshold  <= 11'd1024;
            cfg_reg.flash_period_ms  <= 16'd500;
            cfg_reg.buzzer_threshold <= 11'd1024;
            cfg_reg.note_count       <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RAMP_MS:       cfg_reg.ramp_ms          <= cfg_data;
                REG_FLASH_THRESH:  cfg_reg.flash_threshold  <= cfg_data[10:0];
                REG_FLASH_PERIOD:  cfg_reg.flash_period_ms  <= cfg_data[15:0];
                REG_BUZZER_THRESH: cfg_reg.buzzer_threshold <= cfg_data[10:0];
                REG_NOTE_COUNT:    cfg_reg.note_count       <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

endmodule

### rtl/dlas_ctrl.sv
module dlas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dlas_pkg::opcode_t    in_op,
    input  dlas_pkg::dp_status_t status,
    output dlas_pkg::dp_cmd_t    cmd
);
    import dlas_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_UPDATE: state_next = ST_PREP;
                        OP_STOP:   state_next = ST_FINISH;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PREP:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.capture  = accept;
            ST_PREP:   cmd.prep     = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_FINISH: cmd.commit   = status.out_free;
            default:   cmd = '0;
        endcase
    end

    // A result is only written when the output register can take it.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output register is full");

    // A load word never starts the arithmetic sequence.
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_op == OP_LOAD) |=> (state_reg == ST_IDLE))
        else $error("load word left the idle state");

endmodule

### rtl/dlas_datapath.sv
module dlas_datapath #(
    parameter int MAX_NOTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dlas_pkg::dp_cmd_t             cmd,
    output dlas_pkg::dp_status_t          status,
    input  dlas_pkg::opcode_t             in_op,
    input  logic [dlas_pkg::InDataW-1:0]  in_data,
    input  dlas_pkg::cfg_t                cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dlas_pkg::OutDataW-1:0] out_data
);
    import dlas_pkg::*;

    localparam int NW = $clog2(MAX_NOTES + 1);
    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam logic [7:0] MaxNotes8 = 8'(MAX_NOTES);

    // Captured item.
    opcode_t           op_reg;
    logic [ProgW-1:0]  prog_reg;
    logic [TimeW-1:0]  now_reg;

    // Block state.
    logic [TimeW-1:0]  ramp_origin_reg;
    logic [TimeW-1:0]  last_toggle_reg;
    logic              flash_on_reg;
    logic [TimeW-1:0]  note_start_reg;
    logic              playing_reg;
    logic [NW-1:0]     next_note_reg;

    logic [DurW-1:0]   note_mem [MAX_NOTES];
    logic [DurW-1:0]   rd_data_reg;
    logic [AW-1:0]     rd_addr;

    // Arithmetic intermediates.
    logic [TimeW-1:0]  clip_reg;
    logic [5:0]        x_reg;
    logic [7:0]        green_reg;
    logic [6:0]        blue_reg;
    logic [7:0]        dawn_red_reg;
    logic [NumW-1:0]   rem_reg;
    logic [QuotW-1:0]  quot_reg;
    logic [2:0]        step_reg;

    logic              out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;

    // Input word fields.
    logic [ProgW-1:0]  in_prog;
    logic [TimeW-1:0]  in_now;
    logic [SlotW-1:0]  in_slot;
    logic [DurW-1:0]   in_dur;

    assign in_prog = in_data[10:0];
    assign in_now  = in_data[42:11];
    assign in_slot = in_data[46:43];
    assign in_dur  = in_data[62:47];

    // Effective note count, clamped to 1..MAX_NOTES.
    logic [7:0]    cnt8;
    logic [NW-1:0] cnt;

    always_comb
    begin
        if (cfg.note_count == 5'd0)
        begin
            cnt8 = 8'd1;
        end
        else if ({3'b000, cfg.note_count} > MaxNotes8)
        begin
            cnt8 = MaxNotes8;
        end
        else
        begin
            cnt8 = {3'b000, cfg.note_count};
        end
    end

    assign cnt = cnt8[NW-1:0];

    // The duration of the last started note is read from the table ahead of time.
    always_comb
    begin
        if (next_note_reg != '0)
        begin
            rd_addr = AW'(next_note_reg - NW'(1));
        end
        else
        begin
            rd_addr = AW'(cnt - NW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_op == OP_LOAD && {4'b0000, in_slot} < MaxNotes8)
        begin
            note_mem[AW'(in_slot)] <= in_dur;
        end
        rd_data_reg <= note_mem[rd_addr];
    end

    // Preparation: clipped elapsed time, flash decision, dawn ramp terms.
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] since_toggle;
    logic             toggle;
    logic [17:0]      p_x100;
    logic [19:0]      p_x300;
    logic [9:0]       green_raw;
    logic [9:0]       blue_raw;
    logic [7:0]       green_prep;
    logic [6:0]       blue_prep;

    assign elapsed      = now_reg - ramp_origin_reg;
    assign since_toggle = now_reg - last_toggle_reg;
    assign toggle       = (prog_reg >= cfg.flash_threshold)
                          && (since_toggle >= {16'd0, cfg.flash_period_ms});
    assign p_x100       = 18'(prog_reg) * 18'd100;
    assign p_x300       = 20'(prog_reg) * 20'd300;
    assign green_raw    = 10'((p_x300 - GreenKnee) >> 10);
    assign blue_raw     = 10'((p_x300 - BlueKnee) >> 10);

    always_comb
    begin
        if (p_x300 <= GreenKnee)
        begin
            green_prep = 8'd0;
        end
        else if (green_raw > 10'(GreenFull))
        begin
            green_prep = GreenFull;
        end
        else
        begin
            green_prep = green_raw[7:0];
        end

        if (p_x300 <= BlueKnee)
        begin
            blue_prep = 7'd0;
        end
        else if (blue_raw > 10'(BlueFull))
        begin
            blue_prep = BlueFull;
        end
        else
        begin
            blue_prep = blue_raw[6:0];
        end
    end

    // Dawn red and the numerator of the pre-wake ramp.
    logic [23:0]     dawn_prod;
    logic [NumW-1:0] num;

    assign dawn_prod = 24'(x_reg) * 24'(DawnRedMul);
    assign num       = NumW'(clip_reg) * NumW'(25);

    // One quotient bit per cycle; the quotient never exceeds 25 when ramp_ms is nonzero.
    logic [NumW-1:0] trial;

    assign trial = NumW'(cfg.ramp_ms) << step_reg;

    // Result assembly.
    logic [7:0]       red_c;
    logic [7:0]       green_c;
    logic [6:0]       blue_c;
    logic             start_c;
    logic [3:0]       index_c;
    logic             stop_c;
    logic [NW-1:0]    wrap_note;
    logic [TimeW-1:0] note_elapsed;
    logic             playing_next;
    logic [NW-1:0]    next_note_next;

    assign note_elapsed = now_reg - note_start_reg;
    assign wrap_note    = (next_note_reg >= cnt) ? '0 : next_note_reg;

    always_comb
    begin
        red_c          = 8'd0;
        green_c        = 8'd0;
        blue_c         = 7'd0;
        start_c        = 1'b0;
        index_c        = 4'd0;
        stop_c         = 1'b0;
        playing_next   = playing_reg;
        next_note_next = next_note_reg;
        case (op_reg)
            OP_STOP:
            begin
                stop_c         = 1'b1;
                playing_next   = 1'b0;
                next_note_next = '0;
            end
            OP_UPDATE:
            begin
                if (prog_reg == '0)
                begin
                    red_c = (cfg.ramp_ms == '0) ? PrewakeTop : 8'(quot_reg);
                end
                else if (prog_reg >= ProgFull)
                begin
                    if (flash_on_reg)
                    begin
                        red_c   = RedFull;
                        green_c = GreenFull;
                        blue_c  = BlueFull;
                    end
                end
                else
                begin
                    red_c   = (prog_reg < ProgHalf) ? dawn_red_reg : RedFull;
                    green_c = green_reg;
                    blue_c  = blue_reg;
                end

                if (prog_reg >= cfg.buzzer_threshold)
                begin
                    if (!playing_reg)
                    begin
                        start_c        = 1'b1;
                        index_c        = 4'(wrap_note);
                        playing_next   = 1'b1;
                        next_note_next = wrap_note + NW'(1);
                    end
                    else if (note_elapsed >= {16'd0, rd_data_reg})
                    begin
                        stop_c       = 1'b1;
                        playing_next = 1'b0;
                    end
                end
                else
                begin
                    stop_c         = 1'b1;
                    playing_next   = 1'b0;
                    next_note_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_origin_reg <= '0;
            last_toggle_reg <= '0;
            flash_on_reg    <= 1'b0;
            note_start_reg  <= '0;
            playing_reg     <= 1'b0;
            next_note_reg   <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !cmd.commit)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.prep && toggle)
            begin
                last_toggle_reg <= now_reg;
                flash_on_reg    <= !flash_on_reg;
            end
            if (cmd.mul)
            begin
                step_reg <= 3'(QuotW - 1);
            end
            else if (cmd.div_step && step_reg != '0)
            begin
                step_reg <= step_reg - 3'd1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                playing_reg   <= playing_next;
                next_note_reg <= next_note_next;
                if (start_c)
                begin
                    note_start_reg <= now_reg;
                end
                if (op_reg == OP_STOP)
                begin
                    flash_on_reg    <= 1'b0;
                    ramp_origin_reg <= now_reg;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            prog_reg <= in_prog;
            now_reg  <= in_now;
        end
        if (cmd.prep)
        begin
            clip_reg  <= (elapsed > cfg.ramp_ms) ? cfg.ramp_ms : elapsed;
            x_reg     <= 6'(p_x100 >> 10);
            green_reg <= green_prep;
            blue_reg  <= blue_prep;
        end
        if (cmd.mul)
        begin
            dawn_red_reg <= PrewakeTop + 8'(dawn_prod >> 15);
            rem_reg      <= num;
            quot_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg            <= rem_reg - trial;
                quot_reg[step_reg] <= 1'b1;
            end
        end
        if (cmd.commit)
        begin
            out_data_reg <= {3'b000, stop_c, index_c, start_c, blue_c, green_c, red_c};
        end
    end

    assign status.div_done = (step_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'(QuotW - 1))
        else $error("divider step out of range");

    a_start_xor_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(start_c && stop_c))
        else $error("note start and stop in one result");

endmodule

### rtl/dawn_light_alarm_sequencer_core.sv
// Update word: captured, then taken through prep, multiply and the five-step pre-wake ramp
// divider that follows the x25 product. Stop word: captured only. Both are committed once
// the output register is free; no new word is taken until then. Load word: no result.
// A finished result waits in the output register while the next word is accepted.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// clears ramp, flash and buzzer state; the note table keeps no reset value.
module dawn_light_alarm_sequencer_core #(
    parameter int MAX_NOTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // progress_q10[10:0], now_ms[42:11], entry_index[46:43], entry_duration[62:47]
    input  logic [63:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_level[7:0], green_level[15:8], blue_level[22:16], tone_start[23],
    // note_index[27:24], tone_stop[28]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dlas_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;
    opcode_t    in_op;

    assign in_op = opcode_t'(s_axis_tuser);

    dlas_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (in_op),
        .status   (status),
        .cmd      (cmd)
    );

    dlas_datapath #(
        .MAX_NOTES (MAX_NOTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (in_op),
        .in_data   (s_axis_tdata),
        .cfg       (cfg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
